[sv/aes_pkg.sv]
// AES-128 package: S-box, GF helpers, round transforms.
package aes_pkg;

  localparam int unsigned NumRounds = 10;

  typedef logic [127:0] block_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // multiply by x mod 0x11B
  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // block byte i sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
    return b[127 - 8*i -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8*(r + 4*c) -: 8] = sbox(get_byte(s, r + 4*((c + r) % 4)));
      end
    end
    return t;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 8*(4*c)     -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[127 - 8*(4*c + 1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[127 - 8*(4*c + 2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[127 - 8*(4*c + 3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // next round key from previous one and round constant
  function automatic block_t next_key(input block_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // round constant for round r (1..10)
  function automatic logic [7:0] rcon(input int unsigned r);
    logic [7:0] v;
    v = 8'h01;
    for (int i = 1; i < 10; i++) begin
      if (i < r) v = xtime(v);
    end
    return v;
  endfunction

endpackage

[sv/aes_round.sv]
// One registered AES round stage with its on-the-fly key expansion.
module aes_round #(
  parameter int unsigned RoundIdx = 1,
  parameter bit          IsFinal  = 1'b0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  aes_pkg::block_t in_state,
  input  aes_pkg::block_t in_key,
  output logic            out_valid,
  output aes_pkg::block_t out_state,
  output aes_pkg::block_t out_key
);
  import aes_pkg::*;

  block_t key_next;
  block_t state_next;
  block_t shifted;

  always_comb begin
    key_next = next_key(in_key, rcon(RoundIdx));
    shifted  = sub_shift(in_state);
    if (IsFinal) begin
      state_next = shifted ^ key_next;
    end else begin
      state_next = mix_columns(shifted) ^ key_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_state <= state_next;
    out_key   <= key_next;
  end

endmodule

[sv/aes128_block_encrypt.sv]
// AES-128 encryption top level: key registers, input whitening, round pipeline.
//
// Usage:
//  - Key: write key_high at cfg_index 0 and key_low at cfg_index 1 through
//    cfg_we/cfg_index/cfg_data. Writes take effect at once; change the key
//    only while no item is in flight. cfg_index is one bit, so no other index exists.
//  - Input: an item (plain_high, plain_low) is taken at a rising edge with
//    start high and busy low. busy is always low, so an item may enter on
//    every clock.
//  - Output: cipher_high/cipher_low are valid for exactly one cycle while
//    done is high. The receiver cannot stall; results are never held.
//  - Pipeline: an accepted item passes one whitening register, then one
//    register per round, before its result is presented.
//  - Throughput: one item per cycle, set by the fully unrolled ten-round
//    pipeline with the key schedule carried alongside each stage.
//  - Reset: rst (synchronous) clears the key to zero and empties the
//    pipeline; no result strobes until new items arrive.
module aes128_block_encrypt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] plain_high,
  input  logic [63:0] plain_low,
  output logic        done,
  output logic [63:0] cipher_high,
  output logic [63:0] cipher_low,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);
  import aes_pkg::*;

  localparam logic RegKeyHigh = 1'b0;
  localparam logic RegKeyLow  = 1'b1;

  logic [63:0] key_high;
  logic [63:0] key_low;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegKeyHigh: key_high <= cfg_data;
        RegKeyLow:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 0: initial AddRoundKey
  logic   whiten_valid;
  block_t whiten_state;
  block_t whiten_key;

  logic   stg_valid [NumRounds+1];
  block_t stg_state [NumRounds+1];
  block_t stg_key   [NumRounds+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      whiten_valid <= 1'b0;
    end else begin
      whiten_valid <= start;
    end
    whiten_state <= {plain_high, plain_low} ^ {key_high, key_low};
    whiten_key   <= {key_high, key_low};
  end

  assign stg_valid[0] = whiten_valid;
  assign stg_state[0] = whiten_state;
  assign stg_key[0]   = whiten_key;

  for (genvar r = 1; r <= NumRounds; r++) begin : g_round
    aes_round #(
      .RoundIdx(r),
      .IsFinal (r == NumRounds)
    ) u_round (
      .clk      (clk),
      .rst      (rst),
      .in_valid (stg_valid[r-1]),
      .in_state (stg_state[r-1]),
      .in_key   (stg_key[r-1]),
      .out_valid(stg_valid[r]),
      .out_state(stg_state[r]),
      .out_key  (stg_key[r])
    );
  end

  assign done        = stg_valid[NumRounds];
  assign cipher_high = stg_state[NumRounds][127:64];
  assign cipher_low  = stg_state[NumRounds][63:0];

endmodule

[tb/sv/aes128_block_encrypt_test.sv]
// Testbench for the AES-128 block encryption pipeline.
module aes128_block_encrypt_test;
  timeunit 1ns;
  timeprecision 1ps;

  import aes_pkg::*;

  // register indexes of the key port
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;
  // extra wait after the result queue empties, before drain returns
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] plain_high = '0;
  logic [63:0] plain_low = '0;
  logic        done;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_KEY_HIGH;
  logic [63:0] cfg_data = '0;

  aes128_block_encrypt u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .plain_high(plain_high), .plain_low(plain_low),
    .done(done), .cipher_high(cipher_high), .cipher_low(cipher_low),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // our own copy of the key registers
  logic [63:0] key_hi_q = '0;
  logic [63:0] key_lo_q = '0;

  logic [127:0] cipher_q[$];
  int           errors = 0;
  int unsigned  cycles = 0;

  // directed rows: key, plaintext, and a known ciphertext where one exists
  typedef struct {
    logic [127:0] key;
    logic [127:0] plain;
    bit           known;
    logic [127:0] cipher;
  } vector_t;

  vector_t vectors[$];

  // S-box lookup, built here from the standard table
  logic [7:0] sub_lut[256];

  function automatic logic [7:0] dbl(input logic [7:0] v);
    dbl = (v << 1) ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block, byte 0 most significant
  function automatic logic [7:0] byte_at(input logic [127:0] b, input int i);
    byte_at = b[127 - 8*i -: 8];
  endfunction

  function automatic logic [127:0] encrypt_block(input logic [127:0] key,
                                                 input logic [127:0] plain);
    logic [7:0]   s[16];
    logic [7:0]   t[16];
    logic [7:0]   rk[176];
    logic [7:0]   w[4];
    logic [7:0]   rc;
    logic [7:0]   h;
    logic [7:0]   a0, a1, a2, a3, x;
    logic [127:0] res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) rk[i] = byte_at(key, i);
    // word recurrence of the key schedule
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) w[j] = rk[i - 4 + j];
      if (i % 16 == 0) begin
        h = w[0];
        w[0] = sub_lut[w[1]] ^ rc;
        w[1] = sub_lut[w[2]];
        w[2] = sub_lut[w[3]];
        w[3] = sub_lut[h];
        rc = dbl(rc);
      end
      for (int j = 0; j < 4; j++) rk[i + j] = rk[i - 16 + j] ^ w[j];
    end
    for (int i = 0; i < 16; i++) s[i] = byte_at(plain, i) ^ rk[i];
    for (int r = 1; r <= 10; r++) begin
      // sub bytes + shift rows, column-major state
      for (int rr = 0; rr < 4; rr++)
        for (int c = 0; c < 4; c++)
          t[rr + 4*c] = sub_lut[s[rr + 4*((c + rr) % 4)]];
      s = t;
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          x = a0 ^ a1 ^ a2 ^ a3;
          s[4*c]   = a0 ^ x ^ dbl(a0 ^ a1);
          s[4*c+1] = a1 ^ x ^ dbl(a1 ^ a2);
          s[4*c+2] = a2 ^ x ^ dbl(a2 ^ a3);
          s[4*c+3] = a3 ^ x ^ dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = s[i] ^ rk[16*r + i];
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = s[i];
    encrypt_block = res;
  endfunction

  // one register write; the caller drops cfg_we after its last write
  task automatic reg_write(input logic idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_KEY_HIGH) key_hi_q = val;
    else key_lo_q = val;
  endtask

  // wait for the pipeline to drain before touching the key
  task automatic drain();
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_key(input logic [127:0] key);
    drain();
    reg_write(REG_KEY_HIGH, key[127:64]);
    reg_write(REG_KEY_LOW, key[63:0]);
    cfg_we <= 1'b0;
  endtask

  // send one item; start stays high across back-to-back items
  task automatic send_item(input logic [127:0] plain, input logic [127:0] want,
                           input bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start      <= 1'b1;
    plain_high <= plain[127:64];
    plain_low  <= plain[63:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    cipher_q.push_back(want);
  endtask

  task automatic idle_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst && done) begin
      if (cipher_q.size() == 0) begin
        $display("%0t: unexpected result %h_%h", $time, cipher_high, cipher_low);
        errors++;
      end else begin
        want = cipher_q.pop_front();
        if (cipher_high !== want[127:64]) begin
          $display("%0t: cipher_high expected %h actual %h",
                   $time, want[127:64], cipher_high);
          errors++;
        end
        if (cipher_low !== want[63:0]) begin
          $display("%0t: cipher_low expected %h actual %h",
                   $time, want[63:0], cipher_low);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [127:0] key;
    logic [127:0] plain;
    logic [127:0] want;
    bit           gaps;
    sub_lut = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    // directed table; the first two rows run on the reset (all-zero) key
    vectors = '{
      '{128'h0, 128'h0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
      '{128'h0, '1, 1'b0, 128'h0},
      // FIPS-197 appendix C.1 and appendix B vectors
      '{128'h000102030405060708090a0b0c0d0e0f, 128'h00112233445566778899aabbccddeeff,
        1'b1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a},
      '{128'h2b7e151628aed2a6abf7158809cf4f3c, 128'h3243f6a8885a308d313198a2e0370734,
        1'b1, 128'h3925841d02dc09fbdc118597196a0b32},
      '{'1, 128'h0, 1'b0, 128'h0},
      '{'1, '1, 1'b0, 128'h0},
      '{{64'h0, 64'hffffffffffffffff}, {64'hffffffffffffffff, 64'h0}, 1'b0, 128'h0},
      '{{64'hffffffffffffffff, 64'h0}, {64'h0, 64'hffffffffffffffff}, 1'b0, 128'h0},
      '{128'h80000000000000000000000000000000, 128'h1, 1'b0, 128'h0},
      '{128'h1, 128'h80000000000000000000000000000000, 1'b0, 128'h0},
      '{128'haaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa, 128'h55555555555555555555555555555555,
        1'b0, 128'h0}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (vectors[i]) begin
      if (i > 0 && vectors[i].key != {key_hi_q, key_lo_q}) begin
        idle_start();
        load_key(vectors[i].key);
      end
      want = vectors[i].known ? vectors[i].cipher
                              : encrypt_block({key_hi_q, key_lo_q}, vectors[i].plain);
      send_item(vectors[i].plain, want, 1'b0);
    end
    idle_start();

    // a write to the unused index pattern: both indexes are real here, so rewrite
    // the low half alone to vary one register at a time
    load_key(vectors[3].key);
    drain();
    reg_write(REG_KEY_LOW, 64'h0123456789abcdef);
    cfg_we <= 1'b0;

    // random: new key per phase; gaps in 2 of 3 runs of 40, none near the end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0 && n > 0) begin
        idle_start();
        // the sender holds off until every result is back
        key = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 5))
          0: key = '0;
          1: key = '1;
          default: ;
        endcase
        load_key(key);
      end
      plain = {$urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(0, 19) == 0) plain = $urandom_range(0, 1) ? '0 : '1;
      gaps = (n < RANDOM_ITEMS - 300) && ((n / 40) % 3 != 2);
      send_item(plain, encrypt_block({key_hi_q, key_lo_q}, plain), gaps);
    end
    idle_start();

    drain();
    if (errors == 0 && cipher_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
